@@ rtl/lru_set_assoc_cache_sim_macros.svh @@
// Assertion macros for the cache lookup model.
// Taken by `include in the modules that check their own logic; needs clock and reset in scope.
`ifndef LRU_SET_ASSOC_CACHE_SIM_MACROS_SVH
`define LRU_SET_ASSOC_CACHE_SIM_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define LSAC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define LSAC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/lsac_pkg.sv @@
// Shared types and constants of the cache lookup model.
// No dependencies.
package lsac_pkg;

   localparam int ADDR_W    = 32;
   localparam int SIZE_W    = 6;
   localparam int CNT_W     = 32;
   localparam int SPAN_W    = 5;
   localparam int CSR_W     = 4;
   localparam int CSR_IDX_W = 2;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [SIZE_W-1:0] MAX_BYTES = 6'd32;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_STORE  = 2'd1;
   localparam logic [1:0] OP_MODIFY = 2'd2;

   localparam logic [1:0] OUT_HIT   = 2'd0;
   localparam logic [1:0] OUT_MISS  = 2'd1;
   localparam logic [1:0] OUT_EVICT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_SET_BITS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WAYS        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_BITS = 2'd2;

   typedef struct packed {
      logic [2:0] set_bits;
      logic [3:0] ways;
      logic [2:0] offset_bits;
   } cfg_type;

   typedef struct packed {
      logic [ADDR_W-1:0] first_blk;
      logic [SPAN_W-1:0] span;
      logic              modify;
   } job_type;

endpackage

@@ rtl/lsac_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lsac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   parameter int AW    = 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/lsac_queue.sv @@
// Short job queue between the front and back parts.
// Depends on lsac_pkg.
module lsac_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lsac_pkg::job_type din,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output lsac_pkg::job_type head
);

   localparam int PW = (lsac_pkg::QUEUE_DEPTH > 1) ? $clog2(lsac_pkg::QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(lsac_pkg::QUEUE_DEPTH + 1);

   lsac_pkg::job_type mem_ff [lsac_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full    = (count_ff == CW'(lsac_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(lsac_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(lsac_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

@@ rtl/lsac_front.sv @@
// Front part: accepts access items, drops empty ones and ones with an unknown opcode, finds the spanned blocks.
// Depends on lsac_pkg.
module lsac_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_opcode,
   input  logic [lsac_pkg::ADDR_W-1:0]   req_byte_address,
   input  logic [lsac_pkg::SIZE_W-1:0]   req_access_size,
   input  lsac_pkg::cfg_type             cfg,
   input  logic                          clearing,
   input  logic                          q_full,
   output logic                          q_push,
   output lsac_pkg::job_type             q_job
);

   logic                          accept;
   logic                          good;
   logic [lsac_pkg::SIZE_W-1:0]   size_c;
   logic                          stg_vld_ff, stg_vld_in;
   logic [lsac_pkg::ADDR_W-1:0]   stg_addr_ff;
   logic [lsac_pkg::ADDR_W:0]     stg_end_ff, stg_end_in;
   logic                          stg_mod_ff;
   logic [lsac_pkg::ADDR_W:0]     last_blk;
   logic [lsac_pkg::ADDR_W:0]     span_wide;

   assign busy   = clearing | (stg_vld_ff & q_full);
   assign accept = start & ~busy;
   assign good   = (req_opcode inside {lsac_pkg::OP_LOAD, lsac_pkg::OP_STORE,
                                       lsac_pkg::OP_MODIFY})
                   && (req_access_size != '0);
   assign size_c = (req_access_size > lsac_pkg::MAX_BYTES) ? lsac_pkg::MAX_BYTES
                                                            : req_access_size;
   assign stg_end_in = {1'b0, req_byte_address}
                       + {{(lsac_pkg::ADDR_W + 1 - lsac_pkg::SIZE_W){1'b0}}, size_c}
                       - {{lsac_pkg::ADDR_W{1'b0}}, 1'b1};
   assign q_push = stg_vld_ff & ~q_full;

   always_comb begin
      stg_vld_in = stg_vld_ff;
      if (accept) begin
         stg_vld_in = good;
      end else if (q_push) begin
         stg_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_vld_ff <= 1'b0;
      end else begin
         stg_vld_ff <= stg_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stg_addr_ff <= req_byte_address;
         stg_end_ff  <= stg_end_in;
         stg_mod_ff  <= (req_opcode == lsac_pkg::OP_MODIFY);
      end
   end

   assign last_blk  = stg_end_ff >> cfg.offset_bits;
   assign q_job.first_blk = stg_addr_ff >> cfg.offset_bits;
   assign span_wide = last_blk - {1'b0, q_job.first_blk};
   assign q_job.span   = span_wide[lsac_pkg::SPAN_W-1:0];
   assign q_job.modify = stg_mod_ff;

endmodule

@@ rtl/lsac_back.sv @@
// Back part: clears the line store, runs one lookup per block and repeat, reports totals.
// Depends on lsac_pkg, lsac_ram and the assertion macro header.
`include "lru_set_assoc_cache_sim_macros.svh"

module lsac_back #(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lsac_pkg::cfg_type             cfg,
   input  logic                          q_empty,
   input  lsac_pkg::job_type             q_head,
   output logic                          q_pop,
   output logic                          clearing,
   output logic                          rsp_strobe,
   output logic [1:0]                    rsp_outcome,
   output logic [lsac_pkg::CNT_W-1:0]    rsp_hit_total,
   output logic [lsac_pkg::CNT_W-1:0]    rsp_miss_total,
   output logic [lsac_pkg::CNT_W-1:0]    rsp_eviction_total,
   output logic                          rsp_last_of_access
);

   localparam int AW       = lsac_pkg::ADDR_W;
   localparam int CW       = lsac_pkg::CNT_W;
   localparam int SET_AW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int NUM_SETS = 1 << MAX_SET_BITS;
   localparam int WAY_AW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int NP       = 1 << WAY_AW;
   localparam int TAG_LO   = MAX_WAYS;
   localparam int STAMP_LO = MAX_WAYS * (1 + AW);
   localparam int ROW_W    = MAX_WAYS * (1 + AW + CW);
   localparam logic [ROW_W-1:0] CLEAR_ROW = {{(MAX_WAYS * CW){1'b1}},
                                              {(MAX_WAYS * (1 + AW)){1'b0}}};

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_READ   = 4'b0100,
      ST_LOOKUP = 4'b1000
   } bst_type;

   bst_type                   st_ff, st_in;
   logic [SET_AW-1:0]         clr_ff, clr_in;
   logic [AW-1:0]             k_ff, k_in;
   logic [lsac_pkg::SPAN_W-1:0] span_ff, span_in;
   logic                      mod_ff, mod_in;
   logic                      rep_ff, rep_in;
   logic [SET_AW-1:0]         set_ff, set_in;
   logic [AW-1:0]             tag_ff, tag_in;
   logic [CW-1:0]             clock_ff, clock_in;
   logic [CW-1:0]             hit_ff, hit_in;
   logic [CW-1:0]             miss_ff, miss_in;
   logic [CW-1:0]             evict_ff, evict_in;
   logic                      rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]                rsp_outcome_ff, rsp_outcome_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic [2:0]                s_eff;
   logic [AW-1:0]             k_src;
   logic [AW-1:0]             blk;
   logic [SET_AW-1:0]         set_src;
   logic [AW-1:0]             tag_src;
   logic                      issue_rd;

   logic                      ram_wr_en;
   logic [SET_AW-1:0]         ram_wr_addr;
   logic [ROW_W-1:0]          ram_wr_data;
   logic [ROW_W-1:0]          rd_row;
   logic [ROW_W-1:0]          upd_row;

   logic                      rv [NP];
   logic [AW-1:0]             rt [NP];
   logic [CW-1:0]             rs [NP];
   logic                      en [NP];
   logic [NP-1:0]             hitv;
   logic [NP-1:0]             invv;
   logic [WAY_AW-1:0]         hit_way;
   logic [WAY_AW-1:0]         inv_way;
   logic [WAY_AW-1:0]         tgt_way;
   logic                      nd_ok    [2 * NP];
   logic [WAY_AW-1:0]         nd_idx   [2 * NP];
   logic [CW-1:0]             nd_stamp [2 * NP];
   logic                      is_hit;
   logic                      have_inv;
   logic                      is_last;

   // Set and tag of the block about to be read
   always_comb begin
      s_eff = (int'(cfg.set_bits) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : cfg.set_bits;
      k_src = (st_ff == ST_IDLE) ? q_head.first_blk : k_ff;
      blk   = k_src & ({AW{1'b1}} >> cfg.offset_bits);
      for (int i = 0; i < SET_AW; i++) begin
         set_src[i] = blk[i] & (i < int'(s_eff));
      end
      tag_src = blk >> s_eff;
   end

   assign q_pop    = (st_ff == ST_IDLE) && !q_empty;
   assign issue_rd = q_pop || (st_ff == ST_READ);
   assign clearing = (st_ff == ST_CLEAR);

   lsac_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NUM_SETS),
      .AW    (SET_AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (issue_rd),
      .rd_addr (set_src),
      .rd_data (rd_row)
   );

   // Compare all ways of the row at once
   always_comb begin
      for (int w = 0; w < NP; w++) begin
         if (w < MAX_WAYS) begin
            rv[w] = rd_row[w];
            rt[w] = rd_row[TAG_LO + w * AW +: AW];
            rs[w] = rd_row[STAMP_LO + w * CW +: CW];
         end else begin
            rv[w] = 1'b0;
            rt[w] = '0;
            rs[w] = '0;
         end
         en[w]   = (w < MAX_WAYS) && ((w == 0) || (w < int'(cfg.ways)));
         hitv[w] = en[w] & rv[w] & (rt[w] == tag_ff);
         invv[w] = en[w] & ~rv[w];
      end

      hit_way = '0;
      inv_way = '0;
      for (int w = NP - 1; w >= 0; w--) begin
         if (hitv[w]) begin
            hit_way = WAY_AW'(w);
         end
         if (invv[w]) begin
            inv_way = WAY_AW'(w);
         end
      end
      is_hit   = |hitv;
      have_inv = |invv;

      for (int j = 0; j < NP; j++) begin
         nd_ok[NP + j]    = en[j];
         nd_idx[NP + j]   = WAY_AW'(j);
         nd_stamp[NP + j] = rs[j];
      end
      nd_ok[0]    = 1'b0;
      nd_idx[0]   = '0;
      nd_stamp[0] = '0;
      for (int n = NP - 1; n >= 1; n--) begin
         if (nd_ok[2 * n + 1] && (!nd_ok[2 * n] || (nd_stamp[2 * n + 1] < nd_stamp[2 * n])))
         begin
            nd_ok[n]    = 1'b1;
            nd_idx[n]   = nd_idx[2 * n + 1];
            nd_stamp[n] = nd_stamp[2 * n + 1];
         end else begin
            nd_ok[n]    = nd_ok[2 * n];
            nd_idx[n]   = nd_idx[2 * n];
            nd_stamp[n] = nd_stamp[2 * n];
         end
      end

      tgt_way = is_hit ? hit_way : (have_inv ? inv_way : nd_idx[1]);

      upd_row = rd_row;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (WAY_AW'(w) == tgt_way) begin
            upd_row[w]                       = 1'b1;
            upd_row[TAG_LO + w * AW +: AW]   = tag_ff;
            upd_row[STAMP_LO + w * CW +: CW] = clock_ff;
         end
      end
   end

   assign ram_wr_en   = (st_ff == ST_CLEAR) || (st_ff == ST_LOOKUP);
   assign ram_wr_addr = (st_ff == ST_CLEAR) ? clr_ff : set_ff;
   assign ram_wr_data = (st_ff == ST_CLEAR) ? CLEAR_ROW : upd_row;
   assign is_last     = (span_ff == '0) && (!mod_ff || rep_ff);

   always_comb begin
      st_in          = st_ff;
      clr_in         = clr_ff;
      k_in           = k_ff;
      span_in        = span_ff;
      mod_in         = mod_ff;
      rep_in         = rep_ff;
      set_in         = set_ff;
      tag_in         = tag_ff;
      clock_in       = clock_ff;
      hit_in         = hit_ff;
      miss_in        = miss_ff;
      evict_in       = evict_ff;
      rsp_strobe_in  = 1'b0;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_last_in    = rsp_last_ff;
      case (st_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == SET_AW'(NUM_SETS - 1)) begin
               st_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_empty) begin
               k_in    = q_head.first_blk;
               span_in = q_head.span;
               mod_in  = q_head.modify;
               rep_in  = 1'b0;
               set_in  = set_src;
               tag_in  = tag_src;
               st_in   = ST_LOOKUP;
            end
         end
         ST_READ: begin
            set_in = set_src;
            tag_in = tag_src;
            st_in  = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            clock_in      = clock_ff + 1'b1;
            rsp_strobe_in = 1'b1;
            rsp_last_in   = is_last;
            if (is_hit) begin
               hit_in         = hit_ff + 1'b1;
               rsp_outcome_in = lsac_pkg::OUT_HIT;
            end else if (have_inv) begin
               miss_in        = miss_ff + 1'b1;
               rsp_outcome_in = lsac_pkg::OUT_MISS;
            end else begin
               miss_in        = miss_ff + 1'b1;
               evict_in       = evict_ff + 1'b1;
               rsp_outcome_in = lsac_pkg::OUT_EVICT;
            end
            if (is_last) begin
               st_in = ST_IDLE;
            end else if (mod_ff && !rep_ff) begin
               rep_in = 1'b1;
               st_in  = ST_READ;
            end else begin
               k_in    = k_ff + 1'b1;
               span_in = span_ff - 1'b1;
               rep_in  = 1'b0;
               st_in   = ST_READ;
            end
         end
         default: begin
            st_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= ST_CLEAR;
         clr_ff        <= '0;
         clock_ff      <= '0;
         hit_ff        <= '0;
         miss_ff       <= '0;
         evict_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         st_ff         <= st_in;
         clr_ff        <= clr_in;
         clock_ff      <= clock_in;
         hit_ff        <= hit_in;
         miss_ff       <= miss_in;
         evict_ff      <= evict_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff           <= k_in;
      span_ff        <= span_in;
      mod_ff         <= mod_in;
      rep_ff         <= rep_in;
      set_ff         <= set_in;
      tag_ff         <= tag_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_outcome        = rsp_outcome_ff;
   assign rsp_hit_total      = hit_ff;
   assign rsp_miss_total     = miss_ff;
   assign rsp_eviction_total = evict_ff;
   assign rsp_last_of_access = rsp_last_ff;

   `LSAC_ASSERT_NEXT(a_lookup_reports, st_ff == ST_LOOKUP, rsp_strobe_ff,
      "lookup gave no result")
   `LSAC_ASSERT_NOW(a_report_from_lookup, rsp_strobe_ff, $past(st_ff) == ST_LOOKUP,
      "result without a lookup")
   `LSAC_ASSERT_NOW(a_totals_step, rsp_strobe_ff,
      CW'(hit_ff + miss_ff) == CW'($past(hit_ff) + $past(miss_ff) + 1'b1),
      "hit and miss totals did not advance by one")
   `LSAC_ASSERT_NOW(a_evict_step, rsp_strobe_ff,
      (evict_ff != $past(evict_ff)) == (rsp_outcome_ff == lsac_pkg::OUT_EVICT),
      "eviction total out of step with outcome")

endmodule

@@ rtl/lru_set_assoc_cache_sim.sv @@
// Top level of the set-associative LRU cache lookup model.
// Depends on lsac_pkg, lsac_front, lsac_queue and lsac_back.
//
//   channel   ports                         handshake
//   request   req_opcode/address/size       start high and busy low at the clock edge
//   result    rsp_outcome, totals, last     rsp_strobe high for one cycle, no back-pressure
//   config    csr_wr_en/index/wr_data       csr_wr_en high at the clock edge
//
// An item is held in the front stage register, then each lookup in the back part first
// reads the set row from the line store and then compares and writes it back.
// A modify takes two lookups per block; an access spanning n blocks takes n (or 2n).
// After reset a clearing pass over all 2^MAX_SET_BITS set rows (64 by default) runs with busy high.
// busy is also high while the front stage holds an item and the two-entry queue is full.
// Results leave on a one-cycle strobe; the receiver cannot stall them.
module lru_set_assoc_cache_sim #(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_opcode,
   input  logic [lsac_pkg::ADDR_W-1:0]       req_byte_address,
   input  logic [lsac_pkg::SIZE_W-1:0]       req_access_size,
   output logic                              rsp_strobe,
   output logic [1:0]                        rsp_outcome,
   output logic [lsac_pkg::CNT_W-1:0]        rsp_hit_total,
   output logic [lsac_pkg::CNT_W-1:0]        rsp_miss_total,
   output logic [lsac_pkg::CNT_W-1:0]        rsp_eviction_total,
   output logic                              rsp_last_of_access,
   input  logic                              csr_wr_en,
   input  logic [lsac_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lsac_pkg::CSR_W-1:0]        csr_wr_data
);

   lsac_pkg::cfg_type cfg_ff, cfg_in;
   lsac_pkg::job_type push_job;
   lsac_pkg::job_type head_job;
   logic              q_push, q_full, q_pop, q_empty;
   logic              clearing;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            lsac_pkg::REG_SET_BITS:    cfg_in.set_bits    = csr_wr_data[2:0];
            lsac_pkg::REG_WAYS:        cfg_in.ways        = csr_wr_data[3:0];
            lsac_pkg::REG_OFFSET_BITS: cfg_in.offset_bits = csr_wr_data[2:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.set_bits    <= 3'd0;
         cfg_ff.ways        <= 4'd1;
         cfg_ff.offset_bits <= 3'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lsac_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_byte_address (req_byte_address),
      .req_access_size  (req_access_size),
      .cfg              (cfg_ff),
      .clearing         (clearing),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_job            (push_job)
   );

   lsac_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (push_job),
      .full  (q_full),
      .pop   (q_pop),
      .empty (q_empty),
      .head  (head_job)
   );

   lsac_back #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .q_empty            (q_empty),
      .q_head             (head_job),
      .q_pop              (q_pop),
      .clearing           (clearing),
      .rsp_strobe         (rsp_strobe),
      .rsp_outcome        (rsp_outcome),
      .rsp_hit_total      (rsp_hit_total),
      .rsp_miss_total     (rsp_miss_total),
      .rsp_eviction_total (rsp_eviction_total),
      .rsp_last_of_access (rsp_last_of_access)
   );

endmodule
